[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, switched off while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the cycle after the antecedent, switched off while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALW(label, clk, expr, msg) \
	label: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

[hdl/pgiad_pkg.sv]
package pgiad_pkg;

	localparam int STAMP_W = 48;
	localparam int SIZE_W  = 32;
	localparam int BYTES_W = 16;
	localparam int GAP_W   = 49;
	localparam int SGAP_W  = 33;
	localparam int RUN_W   = 8;

	localparam int GSPAN_W = 20;
	localparam int JUMP_W  = 27;
	localparam int LIMIT_W = 8;
	localparam int BGAP_W  = 20;
	localparam int BSPAN_W = 24;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int IN_W   = 3 * STAMP_W + BYTES_W;
	localparam int OUT_W  = 136;
	localparam int PAD_W  = OUT_W - 2 * GAP_W - SGAP_W;

	localparam logic [GSPAN_W-1:0] GROUP_SPAN_RST  = GSPAN_W'(5000);
	localparam logic [JUMP_W-1:0]  OFFSET_JUMP_RST = JUMP_W'(3000000);
	localparam logic [LIMIT_W-1:0] REORDER_LIM_RST = LIMIT_W'(3);
	localparam logic [BGAP_W-1:0]  BURST_GAP_RST   = BGAP_W'(5000);
	localparam logic [BSPAN_W-1:0] BURST_SPAN_RST  = BSPAN_W'(100000);

	typedef enum logic [2:0] {
		REG_GROUP_SPAN    = 3'd0,
		REG_OFFSET_JUMP   = 3'd1,
		REG_REORDER_LIMIT = 3'd2,
		REG_BURST_GAP     = 3'd3,
		REG_BURST_SPAN    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [GSPAN_W-1:0] group_span;
		logic [JUMP_W-1:0]  offset_jump;
		logic [LIMIT_W-1:0] reorder_limit;
		logic [BGAP_W-1:0]  burst_gap;
		logic [BSPAN_W-1:0] burst_span;
	} cfg_t;

	// First member sits in the top bits, so send_stamp lands in the low bits of tdata.
	typedef struct packed {
		logic [BYTES_W-1:0] byte_count;
		logic [STAMP_W-1:0] local_stamp;
		logic [STAMP_W-1:0] arrival_stamp;
		logic [STAMP_W-1:0] send_stamp;
	} item_t;

	typedef struct packed {
		logic                    deltas_valid;
		logic signed [GAP_W-1:0]  send_gap;
		logic signed [GAP_W-1:0]  arrival_gap;
		logic signed [SGAP_W-1:0] size_gap;
	} result_t;

endpackage

[hdl/pgiad_cfg.sv]
module pgiad_cfg import pgiad_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.group_span    <= GROUP_SPAN_RST;
			cfg_q.offset_jump   <= OFFSET_JUMP_RST;
			cfg_q.reorder_limit <= REORDER_LIM_RST;
			cfg_q.burst_gap     <= BURST_GAP_RST;
			cfg_q.burst_span    <= BURST_SPAN_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_GROUP_SPAN:    cfg_q.group_span    <= pwdata[GSPAN_W-1:0];
				REG_OFFSET_JUMP:   cfg_q.offset_jump   <= pwdata[JUMP_W-1:0];
				REG_REORDER_LIMIT: cfg_q.reorder_limit <= pwdata[LIMIT_W-1:0];
				REG_BURST_GAP:     cfg_q.burst_gap     <= pwdata[BGAP_W-1:0];
				REG_BURST_SPAN:    cfg_q.burst_span    <= pwdata[BSPAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_GROUP_SPAN:    prdata = {{(DATA_W-GSPAN_W){1'b0}}, cfg_q.group_span};
			REG_OFFSET_JUMP:   prdata = {{(DATA_W-JUMP_W){1'b0}}, cfg_q.offset_jump};
			REG_REORDER_LIMIT: prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg_q.reorder_limit};
			REG_BURST_GAP:     prdata = {{(DATA_W-BGAP_W){1'b0}}, cfg_q.burst_gap};
			REG_BURST_SPAN:    prdata = {{(DATA_W-BSPAN_W){1'b0}}, cfg_q.burst_span};
			default:           prdata = '0;
		endcase
	end

endmodule

[hdl/pgiad_group.sv]
module pgiad_group import pgiad_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item,
	input  logic    step,
	output result_t res
);

	typedef struct packed {
		logic               started;
		logic               complete;
		logic [STAMP_W-1:0] first_send;
		logic [STAMP_W-1:0] last_send;
		logic [STAMP_W-1:0] first_arrival;
		logic [STAMP_W-1:0] last_arrival;
		logic [STAMP_W-1:0] last_local;
		logic [SIZE_W-1:0]  bytes;
		logic               prev_complete;
		logic [STAMP_W-1:0] prev_last_send;
		logic [STAMP_W-1:0] prev_last_arrival;
		logic [STAMP_W-1:0] prev_last_local;
		logic [SIZE_W-1:0]  prev_bytes;
		logic [RUN_W-1:0]   run;
	} grp_state_t;

	grp_state_t st_q;
	grp_state_t nxt;

	logic signed [GAP_W-1:0] send_d;
	logic signed [GAP_W-1:0] arr_d;
	logic signed [GAP_W-1:0] span_d;
	logic signed [GAP_W:0]   prop;
	logic                    in_burst;
	logic                    send_reorder;
	logic [STAMP_W-1:0]      first_span;
	logic                    new_group;

	logic signed [GAP_W-1:0]  send_gap;
	logic signed [GAP_W-1:0]  arr_gap;
	logic signed [GAP_W-1:0]  loc_gap;
	logic signed [GAP_W:0]    drift;
	logic                     jump;
	logic signed [SGAP_W-1:0] size_gap;
	logic [RUN_W-1:0]         run_inc;

	logic              rotate;
	logic              accum;
	logic [SIZE_W-1:0] bytes_base;
	logic [SIZE_W:0]   bytes_sum;

	// Burst test against the current group.
	assign send_d   = $signed({1'b0, item.send_stamp}) - $signed({1'b0, st_q.last_send});
	assign arr_d    = $signed({1'b0, item.arrival_stamp}) - $signed({1'b0, st_q.last_arrival});
	assign span_d   = $signed({1'b0, item.arrival_stamp}) - $signed({1'b0, st_q.first_arrival});
	assign prop     = $signed({arr_d[GAP_W-1], arr_d}) - $signed({send_d[GAP_W-1], send_d});
	assign in_burst = (send_d == '0) ||
		(prop[GAP_W] &&
		 (arr_d <= $signed({{(GAP_W-BGAP_W){1'b0}}, cfg.burst_gap})) &&
		 (span_d < $signed({{(GAP_W-BSPAN_W){1'b0}}, cfg.burst_span})));

	assign send_reorder = st_q.first_send > item.send_stamp;
	assign first_span   = item.send_stamp - st_q.first_send;
	assign new_group    = !in_burst &&
		(first_span > {{(STAMP_W-GSPAN_W){1'b0}}, cfg.group_span});

	// Deltas between the current and the previous group.
	assign send_gap = $signed({1'b0, st_q.last_send}) - $signed({1'b0, st_q.prev_last_send});
	assign arr_gap  = $signed({1'b0, st_q.last_arrival}) -
		$signed({1'b0, st_q.prev_last_arrival});
	assign loc_gap  = $signed({1'b0, st_q.last_local}) - $signed({1'b0, st_q.prev_last_local});
	assign drift    = $signed({arr_gap[GAP_W-1], arr_gap}) - $signed({loc_gap[GAP_W-1], loc_gap});
	assign jump     = drift >= $signed({{(GAP_W+1-JUMP_W){1'b0}}, cfg.offset_jump});
	assign size_gap = $signed({1'b0, st_q.bytes}) - $signed({1'b0, st_q.prev_bytes});
	assign run_inc  = (st_q.run == '1) ? st_q.run : st_q.run + RUN_W'(1);

	always_comb begin
		nxt        = st_q;
		res        = '0;
		rotate     = 1'b0;
		accum      = 1'b0;
		bytes_base = st_q.bytes;
		bytes_sum  = '0;

		if (!st_q.started) begin
			nxt.first_send    = item.send_stamp;
			nxt.last_send     = item.send_stamp;
			nxt.first_arrival = item.arrival_stamp;
			accum             = 1'b1;
		end else if (send_reorder) begin
			accum = 1'b0;
		end else if (new_group) begin
			if (!st_q.prev_complete) begin
				rotate = 1'b1;
			end else if (jump) begin
				nxt = '0;
			end else if (arr_gap < 0) begin
				// Groups arrived out of order: count it and drop the word; at the reorder limit, clear all state.
				nxt.run = run_inc;
				if (run_inc >= cfg.reorder_limit) begin
					nxt = '0;
				end
			end else begin
				nxt.run          = '0;
				res.deltas_valid = 1'b1;
				res.send_gap     = send_gap;
				res.arrival_gap  = arr_gap;
				res.size_gap     = size_gap;
				rotate           = 1'b1;
			end
		end else begin
			if (item.send_stamp > st_q.last_send) begin
				nxt.last_send = item.send_stamp;
			end
			accum = 1'b1;
		end

		if (rotate) begin
			nxt.prev_complete     = st_q.complete;
			nxt.prev_last_send    = st_q.last_send;
			nxt.prev_last_arrival = st_q.last_arrival;
			nxt.prev_last_local   = st_q.last_local;
			nxt.prev_bytes        = st_q.bytes;
			nxt.first_send        = item.send_stamp;
			nxt.last_send         = item.send_stamp;
			nxt.first_arrival     = item.arrival_stamp;
			bytes_base            = '0;
			accum                 = 1'b1;
		end

		if (accum) begin
			bytes_sum        = {1'b0, bytes_base} + {{(SIZE_W+1-BYTES_W){1'b0}}, item.byte_count};
			nxt.bytes        = bytes_sum[SIZE_W] ? '1 : bytes_sum[SIZE_W-1:0];
			nxt.last_arrival = item.arrival_stamp;
			nxt.last_local   = item.local_stamp;
			nxt.started      = 1'b1;
			nxt.complete     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			st_q <= nxt;
		end
	end

endmodule

[hdl/packet_group_inter_arrival_delta.sv]
// Packet group inter-arrival delta unit.
// Each input word on the s_ stream is one received packet: its send, arrival and
// local clock stamps in microseconds and its size in bytes. Packets are gathered
// into groups by send-time span, with bursts folded into the current group.
// Every input word yields exactly one output word on the m_ stream, in order.
// m_tuser is high when the word carries the send, arrival and byte-total deltas
// between the group just closed and the one before it; otherwise tdata is zero.
// Five tuning registers sit on the APB port at byte addresses 0, 4, 8, 12, 16.
// A word accepted into the input register is processed as it moves on into the
// output register, where its result is offered. Throughput is one word per cycle
// while m_tready keeps up; the group state update is a single pass of subtractions
// and compares between the input register and the group state registers.
// When m_tready is low the finished result holds in the output register, one
// more word waits in the input register, and s_tready then drops.
// Reset clears the group state, both pipeline stages and loads the default
// register values; no word is in flight afterward.
module packet_group_inter_arrival_delta import pgiad_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// send_stamp[47:0], arrival_stamp[95:48], local_stamp[143:96], byte_count[159:144]
	input  logic [IN_W-1:0]   s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// send_gap[48:0], arrival_gap[97:49], size_gap[130:98], zero[135:131]
	output logic [OUT_W-1:0]  m_tdata,
	// deltas_valid[0]
	output logic              m_tuser,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    step;

	assign step     = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || step;

	pgiad_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pgiad_group u_group (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.step   (step),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (step) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_t'(s_tdata);
		end
		if (step) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.deltas_valid;
	assign m_tdata  = {{PAD_W{1'b0}}, res_s2.size_gap, res_s2.arrival_gap, res_s2.send_gap};

endmodule

[hdl/pgiad_checker.sv]
`include "assert_macros.svh"

module pgiad_checker import pgiad_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tuser
);

	// A stalled output word stays put.
	`ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")

	// Words without deltas carry all-zero data.
	`ASSERT_IMP(a_zero_data, clk, arst_n, m_tvalid && !m_tuser, m_tdata == '0, "nonzero data without deltas")

	// An accepted word reaches the output through the input register if the sink keeps up.
	`ASSERT_NXT(a_latency, clk, arst_n, (s_tvalid && s_tready ##1 m_tready), m_tvalid, "accepted word did not reach the output")

	// Nothing is offered while reset is asserted.
	`ASSERT_ALW(a_reset_idle, clk, arst_n || !m_tvalid, "output valid during reset")

endmodule

bind packet_group_inter_arrival_delta pgiad_checker u_checker (.*);

[dv/packet_group_inter_arrival_delta_tb.sv]
module packet_group_inter_arrival_delta_tb import pgiad_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// Full-size packets folded into one group by a long burst.
	localparam int BIG_BURST = 40;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	// send_stamp[47:0], arrival_stamp[95:48], local_stamp[143:96], byte_count[159:144]
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	// send_gap[48:0], arrival_gap[97:49], size_gap[130:98], zero[135:131]
	logic [OUT_W-1:0]  m_tdata;
	// deltas_valid[0]
	logic              m_tuser;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	packet_group_inter_arrival_delta dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Tuning registers as the block should hold them.
	logic [GSPAN_W-1:0] tune_span  = GROUP_SPAN_RST;
	logic [JUMP_W-1:0]  tune_jump  = OFFSET_JUMP_RST;
	logic [LIMIT_W-1:0] tune_limit = REORDER_LIM_RST;
	logic [BGAP_W-1:0]  tune_bgap  = BURST_GAP_RST;
	logic [BSPAN_W-1:0] tune_bspan = BURST_SPAN_RST;

	// Group tracking state: the group being filled and the one closed before it.
	logic               grp_open, grp_full, old_full;
	logic [STAMP_W-1:0] grp_first_send, grp_last_send, grp_first_arr, grp_last_arr;
	logic [STAMP_W-1:0] grp_last_loc, old_last_send, old_last_arr, old_last_loc;
	logic [SIZE_W-1:0]  grp_bytes, old_bytes;
	logic [RUN_W-1:0]   reorder_count;

	result_t pending_deltas[$];
	int      errors = 0;
	bit      src_idle = 1'b0;
	bit      snk_idle = 1'b0;
	int      sink_wait = 0;
	int      stall_cycles = 0;

	// Traffic generator: running send and arrival stamps and local clock skew.
	logic [STAMP_W-1:0] gen_send, gen_arr, gen_skew;

	function automatic void forget_history();
		grp_open = 1'b0;
		grp_full = 1'b0;
		old_full = 1'b0;
		grp_first_send = '0;
		grp_last_send = '0;
		grp_first_arr = '0;
		grp_last_arr = '0;
		grp_last_loc = '0;
		grp_bytes = '0;
		old_last_send = '0;
		old_last_arr = '0;
		old_last_loc = '0;
		old_bytes = '0;
		reorder_count = '0;
	endfunction

	function automatic result_t group_deltas(input item_t pkt);
		result_t r;
		logic signed [63:0] sd, ad, prop, span, sg, ag, lg, sz;
		logic [SIZE_W:0] total;
		logic burst;
		r = '0;
		if (!grp_open) begin
			grp_first_send = pkt.send_stamp;
			grp_last_send = pkt.send_stamp;
			grp_first_arr = pkt.arrival_stamp;
		end else if (grp_first_send > pkt.send_stamp) begin
			return r;
		end else begin
			sd = 64'(pkt.send_stamp) - 64'(grp_last_send);
			ad = 64'(pkt.arrival_stamp) - 64'(grp_last_arr);
			prop = ad - sd;
			span = 64'(pkt.arrival_stamp) - 64'(grp_first_arr);
			burst = (sd == 0) || (prop < 0 && ad <= $signed(64'(tune_bgap))
				&& span < $signed(64'(tune_bspan)));
			if (!burst && (64'(pkt.send_stamp) - 64'(grp_first_send)) > 64'(tune_span)) begin
				if (old_full) begin
					sg = 64'(grp_last_send) - 64'(old_last_send);
					ag = 64'(grp_last_arr) - 64'(old_last_arr);
					lg = 64'(grp_last_loc) - 64'(old_last_loc);
					if (ag - lg >= $signed(64'(tune_jump))) begin
						forget_history();
						return r;
					end
					if (ag < 0) begin
						if (reorder_count != '1)
							reorder_count = reorder_count + 1'b1;
						if (reorder_count >= tune_limit)
							forget_history();
						return r;
					end
					reorder_count = '0;
					sz = 64'(grp_bytes) - 64'(old_bytes);
					r.deltas_valid = 1'b1;
					r.send_gap = sg[GAP_W-1:0];
					r.arrival_gap = ag[GAP_W-1:0];
					r.size_gap = sz[SGAP_W-1:0];
				end
				old_full = grp_full;
				old_last_send = grp_last_send;
				old_last_arr = grp_last_arr;
				old_last_loc = grp_last_loc;
				old_bytes = grp_bytes;
				grp_first_send = pkt.send_stamp;
				grp_last_send = pkt.send_stamp;
				grp_first_arr = pkt.arrival_stamp;
				grp_bytes = '0;
			end else if (pkt.send_stamp > grp_last_send) begin
				grp_last_send = pkt.send_stamp;
			end
		end
		total = (SIZE_W+1)'(grp_bytes) + (SIZE_W+1)'(pkt.byte_count);
		grp_bytes = total[SIZE_W] ? '1 : total[SIZE_W-1:0];
		grp_last_arr = pkt.arrival_stamp;
		grp_last_loc = pkt.local_stamp;
		grp_open = 1'b1;
		grp_full = 1'b1;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(input reg_idx_t idx);
		return {idx, 2'b00};
	endfunction

	function automatic logic [DATA_W-1:0] tuning_value(input reg_idx_t idx);
		case (idx)
			REG_GROUP_SPAN:    return DATA_W'(tune_span);
			REG_OFFSET_JUMP:   return DATA_W'(tune_jump);
			REG_REORDER_LIMIT: return DATA_W'(tune_limit);
			REG_BURST_GAP:     return DATA_W'(tune_bgap);
			REG_BURST_SPAN:    return DATA_W'(tune_bspan);
			default:           return '0;
		endcase
	endfunction

	function automatic void apply_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] val);
		case (addr[ADDR_W-1:2])
			REG_GROUP_SPAN:    tune_span = val[GSPAN_W-1:0];
			REG_OFFSET_JUMP:   tune_jump = val[JUMP_W-1:0];
			REG_REORDER_LIMIT: tune_limit = val[LIMIT_W-1:0];
			REG_BURST_GAP:     tune_bgap = val[BGAP_W-1:0];
			REG_BURST_SPAN:    tune_bspan = val[BSPAN_W-1:0];
			default: ;
		endcase
	endfunction

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		apply_reg(addr, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic read_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want) begin
			$error("prdata at 0x%0h: expected 0x%0h, got 0x%0h", addr, want, prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_all_regs();
		for (int i = REG_GROUP_SPAN; i <= REG_BURST_SPAN; i++)
			read_reg(addr_of(reg_idx_t'(i)), tuning_value(reg_idx_t'(i)));
	endtask

	// Random junk goes above each register's width; the block must drop it.
	task automatic set_tuning(input int span, input int jump, input int limit,
			input int bgap, input int bspan);
		write_reg(addr_of(REG_GROUP_SPAN), (DATA_W'($urandom) << GSPAN_W) | DATA_W'(span));
		write_reg(addr_of(REG_OFFSET_JUMP), (DATA_W'($urandom) << JUMP_W) | DATA_W'(jump));
		write_reg(addr_of(REG_REORDER_LIMIT), (DATA_W'($urandom) << LIMIT_W) | DATA_W'(limit));
		write_reg(addr_of(REG_BURST_GAP), (DATA_W'($urandom) << BGAP_W) | DATA_W'(bgap));
		write_reg(addr_of(REG_BURST_SPAN), (DATA_W'($urandom) << BSPAN_W) | DATA_W'(bspan));
		check_all_regs();
	endtask

	// Valid stays high between back-to-back words; it only drops when a gap is drawn.
	task automatic send_packet(input item_t pkt);
		int gap;
		gap = src_idle ? $urandom_range(0, 17) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pkt;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_deltas.push_back(group_deltas(pkt));
	endtask

	task automatic send_stamps(input logic [STAMP_W-1:0] s, input logic [STAMP_W-1:0] a,
			input logic [STAMP_W-1:0] l, input logic [BYTES_W-1:0] b);
		send_packet({b, l, a, s});
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		for (int n = 0; n < 5000 && pending_deltas.size() != 0; n++)
			@(posedge clk);
		if (pending_deltas.size() != 0) begin
			$error("%0d result words never arrived", pending_deltas.size());
			errors++;
		end
		repeat (4) @(posedge clk);
	endtask

	function automatic void move_arrival(input int d);
		if (d < 0)
			gen_arr = gen_arr - STAMP_W'(-d);
		else
			gen_arr = gen_arr + STAMP_W'(d);
	endfunction

	function automatic void reseed_traffic();
		gen_send = {2'b00, 14'($urandom), 32'($urandom)} + STAMP_W'(1000000);
		gen_arr = {1'b0, 15'($urandom), 32'($urandom)};
		gen_skew = {16'($urandom), 32'($urandom)};
	endfunction

	// Mostly well-formed packet streams, with reorders, clock jumps and noise mixed in.
	function automatic item_t next_traffic_packet();
		item_t p;
		int pick, step, jit, jump_amt;
		if (grp_open && grp_first_send > gen_send) begin
			gen_send = grp_last_send;
			gen_arr = grp_last_arr;
			gen_skew = grp_last_loc - grp_last_arr;
		end
		pick = $urandom_range(0, 99);
		p.send_stamp = gen_send;
		if (pick < 38) begin
			step = tune_span + 1 + $urandom_range(0, tune_span + 2000);
			jit = int'($urandom_range(0, 6000)) - 3000;
			gen_send = gen_send + STAMP_W'(step);
			move_arrival(step + jit);
			p.send_stamp = gen_send;
		end else if (pick < 62) begin
			step = $urandom_range(0, tune_span / 4);
			jit = int'($urandom_range(0, 1000)) - 500;
			gen_send = gen_send + STAMP_W'(step);
			move_arrival(step + jit);
			p.send_stamp = gen_send;
		end else if (pick < 72) begin
			move_arrival($urandom_range(0, 200));
		end else if (pick < 77) begin
			move_arrival(-int'($urandom_range(1, 20000)));
		end else if (pick < 82) begin
			step = tune_span + $urandom_range(0, 1);
			gen_send = gen_send + STAMP_W'(step);
			move_arrival(step);
			p.send_stamp = gen_send;
		end else if (pick < 87) begin
			p.send_stamp = gen_send - STAMP_W'($urandom_range(1, 20000));
			move_arrival($urandom_range(0, 500));
		end else if (pick < 91) begin
			// Arrival clock leaps while the local clock keeps its pace.
			jump_amt = tune_jump + $urandom_range(0, 2000);
			step = tune_span + 1;
			gen_send = gen_send + STAMP_W'(step);
			move_arrival(step + jump_amt);
			gen_skew = gen_skew - STAMP_W'(jump_amt);
			p.send_stamp = gen_send;
		end else if (pick < 94) begin
			jit = int'($urandom_range(0, 20000)) - 10000;
			gen_skew = gen_skew + STAMP_W'(jit);
			move_arrival($urandom_range(0, 3000));
		end
		p.arrival_stamp = gen_arr;
		p.local_stamp = gen_arr + gen_skew;
		if (pick >= 94) begin
			p.send_stamp = {16'($urandom), 32'($urandom)};
			p.arrival_stamp = {16'($urandom), 32'($urandom)};
			p.local_stamp = {16'($urandom), 32'($urandom)};
		end
		case ($urandom_range(0, 9))
			0: p.byte_count = '0;
			1: p.byte_count = '1;
			default: p.byte_count = BYTES_W'($urandom);
		endcase
		return p;
	endfunction

	task automatic run_traffic(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				src_idle = ($urandom_range(0, 3) != 0);
				snk_idle = ($urandom_range(0, 3) != 0);
			end
			send_packet(next_traffic_packet());
		end
		wait_idle();
	endtask

	task automatic test_register_file();
		check_all_regs();
		set_tuning(1000000, 100000000, 255, 1000000, 10000000);
		// Writes to the unmapped slots above the last register must change nothing.
		for (int i = REG_BURST_SPAN + 1; i < (1 << (ADDR_W - 2)); i++)
			write_reg(ADDR_W'(i * 4), $urandom);
		check_all_regs();
		set_tuning(0, 1, 1, 0, 0);
		set_tuning(GROUP_SPAN_RST, OFFSET_JUMP_RST, REORDER_LIM_RST, BURST_GAP_RST,
			BURST_SPAN_RST);
	endtask

	task automatic test_directed_cases();
		src_idle = 1'b1;
		snk_idle = 1'b1;
		// All-zero packet opens the first group.
		send_stamps(48'd0, 48'd0, 48'd0, 16'd0);
		// Same send stamp: burst, full-size packet.
		send_stamps(48'd0, 48'd20, 48'd20, 16'hFFFF);
		// Send span exceeded but the packet arrives early and close: merged as a burst.
		send_stamps(48'd6000, 48'd100, 48'd100, 16'd10);
		// Older send stamp inside the group span stays in the group.
		send_stamps(48'd3000, 48'd3100, 48'd3100, 16'd20);
		// New group with no completed group before it: no deltas.
		send_stamps(48'd12000, 48'd12500, 48'd12500, 16'd1000);
		// Send stamp below the group start is dropped.
		send_stamps(48'd11999, 48'd12600, 48'd12600, 16'd7);
		// Exactly at the group span stays in the group.
		send_stamps(48'd17000, 48'd17500, 48'd17500, 16'd1500);
		// One past the span closes the group and reports deltas.
		send_stamps(48'd17001, 48'd24000, 48'd24000, 16'd300);
		// Arrival goes backward, so the next closes see a negative arrival delta.
		send_stamps(48'd18000, 48'd10000, 48'd10000, 16'd1);
		send_stamps(48'd30000, 48'd31000, 48'd31000, 16'd2);
		send_stamps(48'd30100, 48'd31100, 48'd31100, 16'd3);
		// Third reordered close reaches the limit and clears everything.
		send_stamps(48'd30200, 48'd31200, 48'd31200, 16'd4);
		send_stamps(48'd40000, 48'd40000, 48'd40000, 16'd500);
		send_stamps(48'd50000, 48'd50000, 48'd50000, 16'd500);
		send_stamps(48'd60000, 48'd60000, 48'd60000, 16'd500);
		// Arrival clock jumps ahead of the local clock; the close after it clears state.
		send_stamps(48'd61000, 48'd3100000, 48'd61000, 16'd600);
		send_stamps(48'd70000, 48'd3110000, 48'd70000, 16'd700);
		send_stamps(48'd80000, 48'd3120000, 48'd80000, 16'd800);
		wait_idle();
	endtask

	// A long run of full-size packets with one send stamp piles up in a single group.
	task automatic test_long_burst();
		src_idle = 1'b0;
		snk_idle = 1'b0;
		send_stamps(48'd200000, 48'd3240000, 48'd200000, 16'hFFFF);
		send_stamps(48'd206000, 48'd3246000, 48'd206000, 16'hFFFF);
		for (int i = 0; i < BIG_BURST; i++)
			send_stamps(48'd206000, 48'd3246000 + 48'(i), 48'd206000 + 48'(i), 16'hFFFF);
		send_stamps(48'd212000, 48'd3400000, 48'd360000, 16'hFFFF);
		send_stamps(48'd218000, 48'd3406000, 48'd366000, 16'd1);
		wait_idle();
	endtask

	task automatic test_output_backpressure();
		src_idle = 1'b0;
		snk_idle = 1'b0;
		@(posedge clk);
		stall_cycles = 300;
		for (int i = 0; i < 60; i++)
			send_packet(next_traffic_packet());
		wait_idle();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_tuning(GROUP_SPAN_RST, OFFSET_JUMP_RST, REORDER_LIM_RST, BURST_GAP_RST,
					BURST_SPAN_RST);
				1: set_tuning(0, 1, 1, 0, 0);
				2: set_tuning(1000000, 100000000, 255, 1000000, 10000000);
				5: set_tuning($urandom_range(0, 1000000), $urandom_range(1, 100000000),
					$urandom_range(1, 255), $urandom_range(0, 1000000),
					$urandom_range(0, 10000000));
				default: set_tuning($urandom_range(0, 20000), $urandom_range(1, 5000000),
					$urandom_range(1, 6), $urandom_range(0, 20000),
					$urandom_range(0, 300000));
			endcase
			reseed_traffic();
			run_traffic(170);
		end
	endtask

	// A send stamp at the top of the range can never be passed, so this runs last.
	task automatic test_stamp_ceiling();
		src_idle = 1'b1;
		snk_idle = 1'b1;
		send_stamps('1, '1, '1, '1);
		send_stamps('0, '0, '0, '0);
		send_stamps('1, 48'hFFFF_FFFF_FFFE, '1, '1);
		wait_idle();
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("packet_group_inter_arrival_delta verification failed");
		$finish;
	end

	// Output side: a long hold when asked, otherwise a drawn wait after each word.
	initial begin
		forever begin
			@(negedge clk);
			if (stall_cycles > 0) begin
				m_tready <= 1'b0;
				stall_cycles--;
			end else if (sink_wait > 0) begin
				m_tready <= 1'b0;
				sink_wait--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_deltas.size() == 0) begin
				$error("result word with no packet outstanding");
				errors++;
			end else begin
				want = pending_deltas.pop_front();
				if (m_tuser !== want.deltas_valid) begin
					$error("deltas_valid: expected %0d, got %0d", want.deltas_valid, m_tuser);
					errors++;
				end
				if ($signed(m_tdata[GAP_W-1:0]) !== want.send_gap) begin
					$error("send_gap: expected %0d, got %0d", want.send_gap,
						$signed(m_tdata[GAP_W-1:0]));
					errors++;
				end
				if ($signed(m_tdata[2*GAP_W-1:GAP_W]) !== want.arrival_gap) begin
					$error("arrival_gap: expected %0d, got %0d", want.arrival_gap,
						$signed(m_tdata[2*GAP_W-1:GAP_W]));
					errors++;
				end
				if ($signed(m_tdata[2*GAP_W+SGAP_W-1:2*GAP_W]) !== want.size_gap) begin
					$error("size_gap: expected %0d, got %0d", want.size_gap,
						$signed(m_tdata[2*GAP_W+SGAP_W-1:2*GAP_W]));
					errors++;
				end
			end
			sink_wait = snk_idle ? $urandom_range(0, 17) : 0;
		end
	end

	initial begin
		arst_n = 1'b1;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		forget_history();
		reseed_traffic();
		// Reset goes low after time zero so the block sees a clean falling edge.
		#1;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_register_file();
		test_directed_cases();
		test_long_burst();
		test_output_backpressure();
		test_random_traffic();
		test_stamp_ceiling();
		if (errors == 0)
			$display("packet_group_inter_arrival_delta verification clean");
		else
			$display("packet_group_inter_arrival_delta verification failed");
		$finish;
	end

endmodule
